>>> src/isp_pkg.sv
`default_nettype none
package isp_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int DEPTH_DEFAULT = 65536;
    localparam int FRAC_BITS     = 16;
    localparam int PHASE_BITS    = 32;
    localparam int LEN_BITS      = 17;
    localparam int PITCH_BITS    = 20;
    localparam int GAIN_BITS     = 16;
    localparam int ADDR_BITS     = 16;
    localparam int CFG_BITS      = 20;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] CFG_CLIP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_PITCH_STEP  = 2'd1;
    localparam logic [1:0] CFG_GAIN        = 2'd2;

    localparam logic [LEN_BITS-1:0]   LEN_MIN     = 17'd1;
    localparam logic [LEN_BITS-1:0]   LEN_MAX     = 17'd65536;
    localparam logic [LEN_BITS-1:0]   LEN_RESET   = 17'd65536;
    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 20'd65536;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd16384;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [ADDR_BITS-1:0]          address;
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          wrapped;
    } t_rsp;

    typedef struct packed {
        logic diff;
        logic sum;
        logic gain;
    } t_lane_ctl;

endpackage
`default_nettype wire

>>> src/interpolating_sample_player_core.sv
// Stereo sample player with linear interpolation. A load request writes one
// left/right pair into the clip memory; a restart request zeroes the phase.
// A tick request reads the pairs at the phase's integer part and at the next
// index (both read ports of the clip memory in the accept cycle), then passes
// through the per-channel multiplier lanes (difference times fraction, sum,
// times gain) in states S_DF, S_SM and S_GN; its result is registered in
// S_FIN once any earlier result was taken, and no request is accepted until
// the tick returns to S_IDLE. If the advanced phase lies at or beyond twice
// the clip length, the wrap is found by a bit-serial remainder unit, and the
// tick waits in S_FIN until it is done. Loads and restarts are taken while a
// result waits to be collected. DEPTH must be a power of two; the clip
// memory has no reset and is not cleared.
`default_nettype none
module interpolating_sample_player_core #(
    parameter int DEPTH = isp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire isp_pkg::t_req                 i_req,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output isp_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [isp_pkg::CFG_BITS-1:0]  i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int SB = isp_pkg::SAMPLE_BITS;
    localparam int LB = isp_pkg::LEN_BITS;
    localparam int XB = isp_pkg::ADDR_BITS;
    localparam int FB = isp_pkg::FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DF   = 3'd1;
    localparam logic [2:0] S_SM   = 3'd2;
    localparam logic [2:0] S_GN   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                       r_state;
    logic [isp_pkg::PHASE_BITS-1:0]   r_phase;
    logic [LB-1:0]                    r_len;
    logic [isp_pkg::PITCH_BITS-1:0]   r_pitch;
    logic [isp_pkg::GAIN_BITS-1:0]    r_gain;
    logic [isp_pkg::PHASE_BITS:0]     r_sum;
    logic [XB-1:0]                    r_nhi;
    logic                             r_wrap;
    logic                             r_slow;
    logic                             r_out_valid;
    isp_pkg::t_rsp                    r_out;

    logic                  w_accept;
    logic                  w_tick;
    logic [XB-1:0]         w_idx;
    logic [LB-1:0]         w_nxt_full;
    logic [XB-1:0]         w_nxt;
    logic [AW+XB-1:0]      w_ra_ext;
    logic [AW+XB-1:0]      w_rb_ext;
    logic [AW+XB-1:0]      w_wa_ext;
    logic [2*SB-1:0]       w_rd_a;
    logic [2*SB-1:0]       w_rd_b;
    logic [LB-1:0]         w_sum_hi;
    logic [LB:0]           w_len2;
    logic                  w_rem_start;
    logic                  w_rem_busy;
    logic [XB-1:0]         w_rem;
    logic                  w_fin_go;
    logic [LB-1:0]         w_cfg_len;
    isp_pkg::t_lane_ctl    w_ctl;
    logic signed [SB-1:0]  w_left;
    logic signed [SB-1:0]  w_right;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_tick      = w_accept && (i_req.kind == isp_pkg::KIND_TICK);

    assign w_idx      = r_phase[isp_pkg::PHASE_BITS-1:FB];
    assign w_nxt_full = {1'b0, w_idx} + LB'(1);
    assign w_nxt      = (w_nxt_full >= r_len) ? '0 : w_nxt_full[XB-1:0];

    assign w_ra_ext = {{AW{1'b0}}, w_idx};
    assign w_rb_ext = {{AW{1'b0}}, w_nxt};
    assign w_wa_ext = {{AW{1'b0}}, i_req.address};

    isp_ram #(
        .WIDTH (2 * SB),
        .DEPTH (DEPTH)
    ) u_clip_ram (
        .i_clk     (i_clk),
        .i_we      (w_accept && (i_req.kind == isp_pkg::KIND_LOAD)),
        .i_waddr   (w_wa_ext[AW-1:0]),
        .i_wdata   ({i_req.left_in, i_req.right_in}),
        .i_re      (w_tick),
        .i_raddr_a (w_ra_ext[AW-1:0]),
        .i_raddr_b (w_rb_ext[AW-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_ctl.diff = (r_state == S_DF);
    assign w_ctl.sum  = (r_state == S_SM);
    assign w_ctl.gain = (r_state == S_GN);

    isp_mix_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      ($signed(w_rd_a[2*SB-1:SB])),
        .i_b      ($signed(w_rd_b[2*SB-1:SB])),
        .i_frac   (r_phase[FB-1:0]),
        .i_gain   (r_gain),
        .o_sample (w_left)
    );

    isp_mix_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      ($signed(w_rd_a[SB-1:0])),
        .i_b      ($signed(w_rd_b[SB-1:0])),
        .i_frac   (r_phase[FB-1:0]),
        .i_gain   (r_gain),
        .o_sample (w_right)
    );

    assign w_sum_hi    = r_sum[isp_pkg::PHASE_BITS:FB];
    assign w_len2      = {r_len, 1'b0};
    assign w_rem_start = (r_state == S_SM) && ({1'b0, w_sum_hi} >= w_len2);

    isp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_sum_hi),
        .i_divisor  (r_len),
        .o_busy     (w_rem_busy),
        .o_rem      (w_rem)
    );

    assign w_fin_go = (r_state == S_FIN) && !w_rem_busy && (!r_out_valid || i_rsp_ready);

    always_comb begin
        if (i_cfg_data[LB-1:0] < isp_pkg::LEN_MIN) begin
            w_cfg_len = isp_pkg::LEN_MIN;
        end else if (i_cfg_data[LB-1:0] > isp_pkg::LEN_MAX) begin
            w_cfg_len = isp_pkg::LEN_MAX;
        end else begin
            w_cfg_len = i_cfg_data[LB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= isp_pkg::LEN_RESET;
            r_pitch <= isp_pkg::PITCH_RESET;
            r_gain  <= isp_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                isp_pkg::CFG_CLIP_LENGTH: r_len   <= w_cfg_len;
                isp_pkg::CFG_PITCH_STEP:  r_pitch <= i_cfg_data[isp_pkg::PITCH_BITS-1:0];
                isp_pkg::CFG_GAIN:        r_gain  <= i_cfg_data[isp_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_tick) begin
                        r_state <= S_DF;
                    end else if (w_accept && (i_req.kind == isp_pkg::KIND_RESTART)) begin
                        r_phase <= '0;
                    end
                end
                S_DF: r_state <= S_SM;
                S_SM: r_state <= S_GN;
                S_GN: r_state <= S_FIN;
                S_FIN: begin
                    if (w_fin_go) begin
                        r_phase <= {(r_slow ? w_rem : r_nhi), r_sum[FB-1:0]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DF) begin
            r_sum <= {1'b0, r_phase} + {{(isp_pkg::PHASE_BITS - isp_pkg::PITCH_BITS + 1){1'b0}},
                                        r_pitch};
        end
        if (r_state == S_SM) begin
            r_slow <= w_rem_start;
            if (w_sum_hi < r_len) begin
                r_nhi  <= w_sum_hi[XB-1:0];
                r_wrap <= 1'b0;
            end else begin
                r_nhi  <= XB'(w_sum_hi - r_len);
                r_wrap <= 1'b1;
            end
        end
        if (w_fin_go) begin
            r_out.left_out  <= w_left;
            r_out.right_out <= w_right;
            r_out.wrapped   <= r_wrap;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
`default_nettype wire

>>> src/isp_ram.sv
`default_nettype none
module isp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

>>> src/isp_mix_lane.sv
`default_nettype none
module isp_mix_lane (
    input  wire logic                                     i_clk,
    input  wire isp_pkg::t_lane_ctl                       i_ctl,
    input  wire logic signed [isp_pkg::SAMPLE_BITS-1:0]   i_a,
    input  wire logic signed [isp_pkg::SAMPLE_BITS-1:0]   i_b,
    input  wire logic        [isp_pkg::FRAC_BITS-1:0]     i_frac,
    input  wire logic        [isp_pkg::GAIN_BITS-1:0]     i_gain,
    output logic      signed [isp_pkg::SAMPLE_BITS-1:0]   o_sample
);

    localparam int SB  = isp_pkg::SAMPLE_BITS;
    localparam int FB  = isp_pkg::FRAC_BITS;
    localparam int GB  = isp_pkg::GAIN_BITS;
    localparam int VB  = SB + FB + 1;
    localparam int PB  = VB + GB + 1;
    localparam int DB  = SB + FB + 2;
    localparam int SH  = FB + GB - 2;
    localparam int QB  = PB - SH;
    localparam logic signed [QB-1:0] SAT_HI = QB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [QB-1:0] SAT_LO = QB'(-(64'sd1 <<< (SB - 1)));
    localparam logic [PB-1:0]        RND    = PB'(64'd1 << (SH - 1));

    logic signed [SB-1:0]   r_a;
    logic signed [VB-1:0]   r_prod;
    logic signed [VB-1:0]   r_v;
    logic signed [PB-1:0]   r_p;

    logic signed [SB:0]     w_diff;
    logic signed [SB+FB+1:0] w_dprod;
    logic signed [VB+GB:0]  w_gprod;
    logic signed [PB-1:0]   w_rnd;
    logic signed [QB-1:0]   w_q;

    assign w_diff  = {i_b[SB-1], i_b} - {i_a[SB-1], i_a};
    assign w_dprod = DB'(w_diff) * DB'($signed({1'b0, i_frac}));
    assign w_gprod = PB'(r_v) * PB'($signed({1'b0, i_gain}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff) begin
            r_a    <= i_a;
            r_prod <= w_dprod[VB-1:0];
        end
        if (i_ctl.sum) begin
            r_v <= {r_a[SB-1], r_a, {FB{1'b0}}} + r_prod;
        end
        if (i_ctl.gain) begin
            r_p <= w_gprod[PB-1:0];
        end
    end

    // round half up, then clamp
    assign w_rnd = r_p + $signed(RND);
    assign w_q   = w_rnd[PB-1:SH];

    always_comb begin
        if (w_q > SAT_HI) begin
            o_sample = SAT_HI[SB-1:0];
        end else if (w_q < SAT_LO) begin
            o_sample = SAT_LO[SB-1:0];
        end else begin
            o_sample = w_q[SB-1:0];
        end
    end

endmodule
`default_nettype wire

>>> src/isp_rem_unit.sv
`default_nettype none
module isp_rem_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [isp_pkg::LEN_BITS-1:0]   i_dividend,
    input  wire logic [isp_pkg::LEN_BITS-1:0]   i_divisor,
    output logic                                o_busy,
    output logic [isp_pkg::ADDR_BITS-1:0]       o_rem
);

    localparam int NB = isp_pkg::LEN_BITS;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] r_dvd;
    logic [NB-1:0] r_dvs;
    logic [NB-1:0] r_rem;
    logic [CB-1:0] r_cnt;
    logic [NB:0]   w_trial;

    assign w_trial = {r_rem, r_dvd[NB-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CB'(NB);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CB'(1);
        end
    end

    // restoring remainder, one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[NB-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                r_rem <= NB'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= w_trial[NB-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem[isp_pkg::ADDR_BITS-1:0];

endmodule
`default_nettype wire

>>> src/isp_checker.sv
`default_nettype none
module isp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_ready,
    input wire isp_pkg::t_req  i_req,
    input wire logic           o_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire isp_pkg::t_rsp  o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("response dropped before it was taken");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> $stable(o_rsp))
        else $error("stalled response changed");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && (i_req.kind == isp_pkg::KIND_TICK) |=> !o_req_ready)
        else $error("request taken while a tick is in flight");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && (i_req.kind != isp_pkg::KIND_TICK) && !o_rsp_valid
        |=> !o_rsp_valid)
        else $error("response without a tick");

endmodule

bind interpolating_sample_player_core isp_checker u_isp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
`default_nettype wire

>>> tb/tb_interpolating_sample_player_core.sv
`timescale 1ns / 100ps

module tb_interpolating_sample_player_core;
    import isp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam logic [1:0]  KIND_UNDEF   = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    class player_scoreboard;
        logic [LEN_BITS-1:0]           clip_len;
        logic [PITCH_BITS-1:0]         pitch;
        logic [GAIN_BITS-1:0]          vol;
        logic [PHASE_BITS-1:0]         phase;
        logic signed [SAMPLE_BITS-1:0] left_mem  [DEPTH_DEFAULT];
        logic signed [SAMPLE_BITS-1:0] right_mem [DEPTH_DEFAULT];
        bit                            loaded    [DEPTH_DEFAULT];
        t_rsp                          pending_frames[$];
        int unsigned                   errors;
        int unsigned                   frames_seen;

        function new();
            clip_len    = LEN_RESET;
            pitch       = PITCH_RESET;
            vol         = GAIN_RESET;
            phase       = '0;
            errors      = 0;
            frames_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
            case (idx)
                CFG_CLIP_LENGTH: clip_len = val[LEN_BITS-1:0];
                CFG_PITCH_STEP:  pitch    = val[PITCH_BITS-1:0];
                CFG_GAIN:        vol      = val[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_len();
            if (clip_len < LEN_MIN) return LEN_MIN;
            if (clip_len > LEN_MAX) return LEN_MAX;
            return clip_len;
        endfunction

        function int unsigned cur_index();
            return phase[PHASE_BITS-1:FRAC_BITS];
        endfunction

        function int unsigned next_index();
            int unsigned n;
            n = cur_index() + 1;
            if (n >= eff_len()) n = 0;
            return n;
        endfunction

        // Q1.31 lerp, times Q2.14 gain, round half up into Q1.15, saturate
        function logic signed [SAMPLE_BITS-1:0] voice_sample(logic signed [SAMPLE_BITS-1:0] a,
                                                             logic signed [SAMPLE_BITS-1:0] b,
                                                             logic [FRAC_BITS-1:0] f);
            longint v;
            longint p;
            longint r;
            v = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'(f);
            p = v * longint'(vol);
            r = (p + (longint'(1) <<< 29)) >>> 30;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[SAMPLE_BITS-1:0];
        endfunction

        function void note_req(t_req r);
            t_rsp            want;
            int unsigned     at;
            int unsigned     nx;
            longint unsigned sum;
            longint unsigned lim;
            case (r.kind)
                KIND_LOAD: begin
                    left_mem[r.address]  = r.left_in;
                    right_mem[r.address] = r.right_in;
                    loaded[r.address]    = 1'b1;
                end
                KIND_RESTART: phase = '0;
                KIND_TICK: begin
                    at = cur_index();
                    nx = next_index();
                    want.left_out  = voice_sample(left_mem[at], left_mem[nx],
                                                  phase[FRAC_BITS-1:0]);
                    want.right_out = voice_sample(right_mem[at], right_mem[nx],
                                                  phase[FRAC_BITS-1:0]);
                    sum = longint'(phase) + longint'(pitch);
                    lim = longint'(eff_len()) << FRAC_BITS;
                    want.wrapped = (sum >= lim);
                    if (want.wrapped) sum = sum % lim;
                    phase = sum[PHASE_BITS-1:0];
                    pending_frames.push_back(want);
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH frame %0d: %s", frames_seen, msg);
            errors++;
        endtask

        task check_rsp(t_rsp got);
            t_rsp want;
            if (pending_frames.size() == 0) begin
                report("response with no tick outstanding");
                return;
            end
            want = pending_frames.pop_front();
            if (got.left_out !== want.left_out)
                report($sformatf("left_out got %0d want %0d", got.left_out, want.left_out));
            if (got.right_out !== want.right_out)
                report($sformatf("right_out got %0d want %0d", got.right_out, want.right_out));
            if (got.wrapped !== want.wrapped)
                report($sformatf("wrapped got %0b want %0b", got.wrapped, want.wrapped));
            frames_seen++;
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    t_req                req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    t_rsp                rsp;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    player_scoreboard sb;
    int unsigned      burst_left = 0;
    bit               hold_req   = 1'b0;
    int unsigned      cycle_cnt  = 0;

    interpolating_sample_player_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // response side: own stall pattern plus one long hold-off
    rx_mode_t    rx_mode   = RX_OPEN;
    int unsigned rx_left   = 0;
    int unsigned rx_tick   = 0;
    int unsigned hold_cnt  = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) sb.check_rsp(rsp);
        if (hold_req && !hold_done) begin
            hold_cnt  = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   rsp_ready <= 1'b1;
                RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_ready <= (rx_tick % 4 == 0);
                default:   rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_req mk_req(logic [1:0] kind, logic [ADDR_BITS-1:0] addr);
        t_req r;
        r.kind     = kind;
        r.address  = addr;
        r.left_in  = pick_sample();
        r.right_in = pick_sample();
        return r;
    endfunction

    function automatic t_req pair_req(logic [ADDR_BITS-1:0] addr,
                                      logic signed [SAMPLE_BITS-1:0] l,
                                      logic signed [SAMPLE_BITS-1:0] r);
        t_req q;
        q.kind     = KIND_LOAD;
        q.address  = addr;
        q.left_in  = l;
        q.right_in = r;
        return q;
    endfunction

    task automatic push_req(t_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_req(r);
    endtask

    // a tick only ever reads pairs that were loaded
    task automatic send_tick();
        int unsigned at;
        int unsigned nx;
        at = sb.cur_index();
        nx = sb.next_index();
        if (!sb.loaded[at]) push_req(mk_req(KIND_LOAD, ADDR_BITS'(at)));
        if (!sb.loaded[nx]) push_req(mk_req(KIND_LOAD, ADDR_BITS'(nx)));
        push_req(mk_req(KIND_TICK, ADDR_BITS'($urandom)));
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(logic [CFG_BITS-1:0] len, logic [CFG_BITS-1:0] step,
                                logic [CFG_BITS-1:0] vol);
        settle();
        write_reg(CFG_CLIP_LENGTH, len);
        write_reg(CFG_PITCH_STEP, step);
        write_reg(CFG_GAIN, vol);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_BITS-1:0] len;
        logic [CFG_BITS-1:0] step;
        logic [CFG_BITS-1:0] vol;
        int unsigned         sel;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, full-scale samples, top address
        push_req(pair_req(16'd0, 16'sh7FFF, 16'sh8000));
        push_req(pair_req(16'd1, 16'sh8000, 16'sh7FFF));
        push_req(pair_req(16'hFFFF, 16'shFFFF, 16'sh0001));
        send_tick();
        send_tick();
        push_req(mk_req(KIND_UNDEF, 16'hFFFF));
        push_req(mk_req(KIND_RESTART, 16'h0000));

        // half speed, top gain: half-way lerp and saturation
        program_regs(20'd16, 20'd32768, 20'd65535);
        repeat (3) send_tick();

        // zero length acts as one pair
        program_regs(20'd0, 20'd40000, 20'd0);
        push_req(mk_req(KIND_RESTART, 16'h5A5A));
        repeat (3) send_tick();

        // oversize length, fastest pitch
        program_regs(20'd131071, 20'd1048575, 20'd32768);
        repeat (3) send_tick();

        // length lowered under the phase, zero pitch
        program_regs(20'd16, 20'd0, 20'd16384);
        repeat (2) send_tick();

        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0:       len = 16;
                1, 2:    len = $urandom_range(16, 64);
                3:       len = $urandom_range(16, 65536);
                4:       len = 65536;
                default: len = $urandom_range(0, 1) ? 0 : $urandom_range(65537, 131071);
            endcase
            case ($urandom_range(0, 4))
                0:       step = 65536;
                1, 2:    step = $urandom_range(0, 131072);
                3:       step = $urandom_range(0, 1048575);
                default: step = $urandom_range(0, 1) ? 0 : 1048575;
            endcase
            case ($urandom_range(0, 3))
                0:       vol = 16384;
                1:       vol = $urandom_range(0, 32768);
                2:       vol = 32768;
                default: vol = $urandom_range(0, 65535);
            endcase
            program_regs(len, step, vol);
            for (int k = 0; k < 120; k++) begin
                if (ph == 1 && k == 20) hold_req <= 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    send_tick();
                end else if (sel < 85) begin
                    if ($urandom_range(0, 4) == 0)
                        push_req(mk_req(KIND_LOAD, ADDR_BITS'($urandom)));
                    else
                        push_req(mk_req(KIND_LOAD,
                                        ADDR_BITS'($urandom_range(0, sb.eff_len() - 1))));
                end else if (sel < 93) begin
                    push_req(mk_req(KIND_RESTART, ADDR_BITS'($urandom)));
                end else begin
                    push_req(mk_req(KIND_UNDEF, ADDR_BITS'($urandom)));
                end
            end
        end

        settle();
        if (sb.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
